FILE: hdl/lrg_pkg.sv
`default_nettype none
package lrg_pkg;

  // default binary point of the module's fixed-point sample and parameter fields
  localparam int FRAC_BITS_DEF = 16;

  // log-domain word: signed, 32 fraction bits
  localparam int LW        = 48;
  localparam int LG_STEPS  = 32;   // log2 fraction bits, one cell each
  localparam int Q_BITS    = 36;   // quotient bits of d / sigma, one cell each
  localparam int EXP_TERMS = 13;   // Taylor terms of exp, one cell each
  localparam int MAG_W     = 41;   // magnitude out of the 2^t units

  localparam logic [25:0] LN2_Q26   = 26'd46516320;
  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam logic [22:0] LOG2E_Q22 = 23'd6051102;
  localparam logic signed [LW-1:0] LOG2_SQRT2PI_L32 = 48'sd5694044581;
  localparam logic [39:0] SQ_ONE     = 40'h01_0000_0000;
  localparam logic [LW-1:0] POW2_LIMIT = 48'h0028_0000_0000;
  localparam logic [MAG_W-1:0] POW2_CAP = 41'h100_0000_0000;
  localparam logic [32:0] TERM_ONE  = 33'h1_0000_0000;
  localparam logic [30:0] SIGMA_RST = 31'd19661;

  typedef enum logic [0:0] {
    REG_MU    = 1'b0,
    REG_SIGMA = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [31:0]        sample_pos;
    logic signed [31:0] observed;
  } in_t;

  typedef struct packed {
    logic signed [31:0] resid;
    logic signed [31:0] grad_mu;
    logic signed [31:0] grad_sigma;
    logic               bad_position;
    logic               saturated;
  } out_t;

  // normalized operand for the log2 cells
  typedef struct packed {
    logic [5:0]  p;
    logic [31:0] m;
  } nm_t;

  // per-sample side data that rides along the chains
  typedef struct packed {
    logic                 bad;
    logic signed [31:0]   y;
    logic signed [31:0]   mu;
    logic [30:0]          sg;
    logic [5:0]           pa;
    logic [5:0]           pb;
    logic signed [LW-1:0] lgx;
    logic signed [LW-1:0] lgs;
    logic                 dneg;
    logic                 tail;
    logic                 uzero;
    logic                 sqone;
    logic                 sqgt;
    logic [39:0]          e2;
  } cr_t;

  // control of one 2^t lane
  typedef struct packed {
    logic       neg;
    logic       cap;
    logic [5:0] n;
  } pl_t;

  typedef struct packed {
    cr_t           c;
    pl_t [2:0]     ln;
  } tw_t;

  typedef struct packed {
    logic signed [31:0] v;
    logic               s;
  } sat_t;

  // leading-one position and mantissa aligned to bit 31
  function automatic nm_t lg_norm(input logic [39:0] v);
    nm_t r;
    r.p = '0;
    for (int i = 1; i < 40; i++) begin
      if (v[i]) r.p = 6'(i);
    end
    if (r.p >= 6'd31) r.m = 32'(v >> (r.p - 6'd31));
    else r.m = 32'(v << (6'd31 - r.p));
    return r;
  endfunction

  // integer part (p - fb) over the fraction bits from the cells
  function automatic logic signed [LW-1:0] lg_join(input logic [5:0] p,
                                                   input logic [5:0] fb,
                                                   input logic [31:0] frac);
    logic signed [LW-33:0] ip;
    ip = $signed({{(LW-38){1'b0}}, p}) - $signed({{(LW-38){1'b0}}, fb});
    return {ip, frac};
  endfunction

  function automatic sat_t clamp32(input logic signed [42:0] v);
    sat_t r;
    if (v > 43'sd2147483647) begin
      r.v = 32'sh7FFF_FFFF;
      r.s = 1'b1;
    end else if (v < -43'sd2147483648) begin
      r.v = 32'sh8000_0000;
      r.s = 1'b1;
    end else begin
      r.v = 32'(v);
      r.s = 1'b0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/lrg_lg_cell.sv
`default_nettype none
// One log2 fraction bit: square the mantissa, renormalize, shift the bit in.
module lrg_lg_cell import lrg_pkg::*; (
  input  logic        clk,
  input  logic [31:0] m_in,
  input  logic [31:0] frac_in,
  output logic [31:0] m,
  output logic [31:0] frac
);

  logic [63:0] sq;
  logic [32:0] sh;
  logic        b;
  logic [31:0] m_next;

  always_comb begin
    sq = 64'(m_in) * 64'(m_in);
    sh = sq[63:31];
    b  = sh[32];
    m_next = b ? sh[32:1] : sh[31:0];
  end

  always_ff @(posedge clk) begin
    m    <= m_next;
    frac <= {frac_in[30:0], b};
  end

endmodule
`default_nettype wire

FILE: hdl/lrg_div_cell.sv
`default_nettype none
// One restoring division step; divisor is pre-scaled so every cell is alike.
module lrg_div_cell import lrg_pkg::*; #(
  parameter int RW = 55,
  parameter int DW = 54
) (
  input  logic              clk,
  input  logic [RW-1:0]     rem_in,
  input  logic [DW-1:0]     d_in,
  input  logic [Q_BITS-1:0] q_in,
  output logic [RW-1:0]     rem,
  output logic [DW-1:0]     d,
  output logic [Q_BITS-1:0] q
);

  logic          ge;
  logic [RW-1:0] diff;

  always_comb begin
    ge   = rem_in >= RW'(d_in);
    diff = ge ? rem_in - RW'(d_in) : rem_in;
  end

  always_ff @(posedge clk) begin
    rem <= {diff[RW-2:0], 1'b0};
    d   <= d_in;
    q   <= {q_in[Q_BITS-2:0], ge};
  end

endmodule
`default_nettype wire

FILE: hdl/lrg_exp_cell.sv
`default_nettype none
// One Taylor term of exp(z): term *= z, then term /= K; two register stages.
module lrg_exp_cell import lrg_pkg::*; #(
  parameter int K = 1
) (
  input  logic        clk,
  input  logic [32:0] term_in,
  input  logic [33:0] sum_in,
  input  logic [31:0] z_in,
  output logic [32:0] term,
  output logic [33:0] sum,
  output logic [31:0] z
);

  // exact for 32-bit dividends while K <= 16
  localparam logic [36:0] RECIP = 37'(((64'd1 << 36) + 64'(K) - 64'd1) / 64'(K));

  logic [64:0] prod;
  logic [68:0] qprod;
  logic [31:0] p_a;
  logic [33:0] s_a;
  logic [31:0] z_a;

  always_comb begin
    prod  = 65'(term_in) * 65'(z_in);
    qprod = 69'(p_a) * 69'(RECIP);
  end

  // stage a: multiply by z, fold the incoming term into the sum
  always_ff @(posedge clk) begin
    p_a <= prod[63:32];
    s_a <= sum_in + 34'(term_in);
    z_a <= z_in;
  end

  // stage b: divide by K through the reciprocal
  always_ff @(posedge clk) begin
    term <= 33'(qprod >> 36);
    sum  <= s_a;
    z    <= z_a;
  end

endmodule
`default_nettype wire

FILE: hdl/lognormal_residual_gradient.sv
`default_nettype none
// Channel   Ports                        Beat
// --------  ---------------------------  -----------------------------------
// input     start, busy, sample          start & !busy takes one sample
// result    done, result                 done marks one result, one cycle
// config    cfg_wr, cfg_addr, cfg_wdata  cfg_wr writes mu or sigma at once
//
// One sample per cycle while rst is low. The pipeline is built from the
// chains: two 32-cell log2 rows, a 36-cell divider row and 13 two-stage
// Taylor cells for exp, plus 12 single stages.
// Synchronous reset clears the valid line and resets mu and sigma; busy
// is high only while rst is high. The receiver cannot stall; done is never held.
module lognormal_residual_gradient import lrg_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  in_t         sample,
  output logic        done,
  output out_t        result,
  input  logic        cfg_wr,
  input  logic [0:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  localparam int SH  = 32 - FRAC_BITS;
  localparam int SW  = 63 - FRAC_BITS;
  localparam int DW  = SW + 3;
  localparam int RW  = SW + 4;
  localparam int DMW = 64 - FRAC_BITS;
  localparam int DSW = DMW + 1;
  localparam int LAT = 12 + 2 * LG_STEPS + Q_BITS + 2 * EXP_TERMS;
  localparam logic signed [LW-1:0] BOFS =
    LW'(longint'(FRAC_BITS) * 64'sd4294967296) - LOG2_SQRT2PI_L32;

  // configuration registers
  logic signed [31:0] mu;
  logic [30:0]        sigma;

  always_ff @(posedge clk) begin
    if (rst) begin
      mu    <= '0;
      sigma <= SIGMA_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_MU:    mu    <= cfg_wdata;
        REG_SIGMA: sigma <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  // valid line
  logic             accept;
  logic [LAT-1:0]   vld;

  assign busy   = rst;
  assign accept = start & ~busy;
  assign done   = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[LAT-2:0], accept};
  end

  // s0: capture beat and parameters
  logic [31:0]        x0;
  logic signed [31:0] y0;
  logic signed [31:0] mu0;
  logic [30:0]        sg0;

  always_ff @(posedge clk) begin
    x0  <= sample.sample_pos;
    y0  <= sample.observed;
    mu0 <= mu;
    sg0 <= (sigma == '0) ? 31'd1 : sigma;
  end

  // s1: normalize x and sigma, then the first log2 row
  nm_t   nx1, ns1;
  cr_t   c1_next;
  cr_t   ca [0:LG_STEPS];
  logic [31:0] mx1, ms1;
  logic [31:0] lm_x [0:LG_STEPS];
  logic [31:0] lf_x [0:LG_STEPS];
  logic [31:0] lm_s [0:LG_STEPS];
  logic [31:0] lf_s [0:LG_STEPS];

  always_comb begin
    nx1 = lg_norm(40'(x0));
    ns1 = lg_norm(40'(sg0));
    c1_next     = '0;
    c1_next.bad = (x0 == '0);
    c1_next.y   = y0;
    c1_next.mu  = mu0;
    c1_next.sg  = sg0;
    c1_next.pa  = nx1.p;
    c1_next.pb  = ns1.p;
  end

  always_ff @(posedge clk) begin
    ca[0] <= c1_next;
    mx1   <= nx1.m;
    ms1   <= ns1.m;
    for (int k = 0; k < LG_STEPS; k++) ca[k+1] <= ca[k];
  end

  assign lm_x[0] = mx1;
  assign lf_x[0] = '0;
  assign lm_s[0] = ms1;
  assign lf_s[0] = '0;

  for (genvar g = 0; g < LG_STEPS; g++) begin : g_lg1
    lrg_lg_cell u_x (
      .clk(clk), .m_in(lm_x[g]), .frac_in(lf_x[g]), .m(lm_x[g+1]), .frac(lf_x[g+1])
    );
    lrg_lg_cell u_s (
      .clk(clk), .m_in(lm_s[g]), .frac_in(lf_s[g]), .m(lm_s[g+1]), .frac(lf_s[g+1])
    );
  end

  // s2: log2 values, scale |lg x| by ln 2
  logic signed [LW-1:0] lgx2, lgs2, ax2;
  cr_t                  c2_next, c2;
  logic [62:0]          lnp2;

  always_comb begin
    lgx2 = lg_join(ca[LG_STEPS].pa, 6'(FRAC_BITS), lf_x[LG_STEPS]);
    lgs2 = lg_join(ca[LG_STEPS].pb, 6'(FRAC_BITS), lf_s[LG_STEPS]);
    ax2  = (lgx2 < 0) ? -lgx2 : lgx2;
    c2_next     = ca[LG_STEPS];
    c2_next.lgx = lgx2;
    c2_next.lgs = lgs2;
  end

  always_ff @(posedge clk) begin
    c2   <= c2_next;
    lnp2 <= 63'(ax2[36:0]) * 63'(LN2_Q26);
  end

  // s3: d = mu - ln x, its magnitude, divisor and far-tail check
  logic [36:0]           lmag3;
  logic signed [DSW-1:0] lnx3, mux3, d3, ad3;
  logic [DMW-1:0]        dm3;
  logic [SW-1:0]         s3;
  cr_t                   c3_next;
  cr_t                   cd [0:Q_BITS];
  logic [RW-1:0]         rem_w [0:Q_BITS];
  logic [DW-1:0]         dd_w  [0:Q_BITS];
  logic [Q_BITS-1:0]     q_w   [0:Q_BITS];
  logic [RW-1:0]         rem3;
  logic [DW-1:0]         dd3;

  always_comb begin
    lmag3 = lnp2[62:26];
    lnx3  = (c2.lgx < 0) ? -$signed(DSW'(lmag3)) : $signed(DSW'(lmag3));
    mux3  = DSW'(c2.mu);
    d3    = (mux3 <<< SH) - lnx3;
    ad3   = (d3 < 0) ? -d3 : d3;
    dm3   = ad3[DMW-1:0];
    s3    = {c2.sg, {SH{1'b0}}};
    c3_next      = c2;
    c3_next.dneg = d3[DSW-1];
    c3_next.tail = RW'(dm3) >= {s3, 4'b0000};
  end

  always_ff @(posedge clk) begin
    cd[0] <= c3_next;
    rem3  <= RW'(dm3);
    dd3   <= {s3, 3'b000};
    for (int k = 0; k < Q_BITS; k++) cd[k+1] <= cd[k];
  end

  assign rem_w[0] = rem3;
  assign dd_w[0]  = dd3;
  assign q_w[0]   = '0;

  for (genvar g = 0; g < Q_BITS; g++) begin : g_div
    lrg_div_cell #(.RW(RW), .DW(DW)) u_div (
      .clk(clk), .rem_in(rem_w[g]), .d_in(dd_w[g]), .q_in(q_w[g]),
      .rem(rem_w[g+1]), .d(dd_w[g+1]), .q(q_w[g+1])
    );
  end

  // s4: square of u
  logic [Q_BITS-1:0] u4;
  logic [63:0]       sqp4;
  cr_t               c4;

  always_ff @(posedge clk) begin
    c4   <= cd[Q_BITS];
    u4   <= q_w[Q_BITS];
    sqp4 <= 64'(q_w[Q_BITS][35:4]) * 64'(q_w[Q_BITS][35:4]);
  end

  // s5: u^2, distance from one
  logic [39:0]       sq5_next;
  cr_t               c5_next, c5;
  logic [39:0]       sq5, vm5;
  logic [Q_BITS-1:0] u5;

  always_comb begin
    sq5_next = sqp4[63:24];
    c5_next       = c4;
    c5_next.uzero = (u4 == '0);
    c5_next.sqone = (sq5_next == SQ_ONE);
    c5_next.sqgt  = (sq5_next > SQ_ONE);
  end

  always_ff @(posedge clk) begin
    c5  <= c5_next;
    sq5 <= sq5_next;
    u5  <= u4;
    vm5 <= c5_next.sqgt ? sq5_next - SQ_ONE : SQ_ONE - sq5_next;
  end

  // s6: exponent term, normalize u and |u^2-1|, second log2 row
  nm_t         nu6, nv6;
  logic [62:0] ep6;
  cr_t         c6_next;
  cr_t         cb [0:LG_STEPS];
  logic [31:0] mu6, mv6;
  logic [31:0] lm_u [0:LG_STEPS];
  logic [31:0] lf_u [0:LG_STEPS];
  logic [31:0] lm_v [0:LG_STEPS];
  logic [31:0] lf_v [0:LG_STEPS];

  always_comb begin
    nu6 = lg_norm(40'(u5));
    nv6 = lg_norm(vm5);
    ep6 = 63'(sq5) * 63'(LOG2E_Q22);
    c6_next    = c5;
    c6_next.e2 = ep6[62:23];
    c6_next.pa = nu6.p;
    c6_next.pb = nv6.p;
  end

  always_ff @(posedge clk) begin
    cb[0] <= c6_next;
    mu6   <= nu6.m;
    mv6   <= nv6.m;
    for (int k = 0; k < LG_STEPS; k++) cb[k+1] <= cb[k];
  end

  assign lm_u[0] = mu6;
  assign lf_u[0] = '0;
  assign lm_v[0] = mv6;
  assign lf_v[0] = '0;

  for (genvar g = 0; g < LG_STEPS; g++) begin : g_lg2
    lrg_lg_cell u_u (
      .clk(clk), .m_in(lm_u[g]), .frac_in(lf_u[g]), .m(lm_u[g+1]), .frac(lf_u[g+1])
    );
    lrg_lg_cell u_v (
      .clk(clk), .m_in(lm_v[g]), .frac_in(lf_v[g]), .m(lm_v[g+1]), .frac(lf_v[g+1])
    );
  end

  // s7: common exponent B + F and the two gradient offsets
  logic signed [LW-1:0] lgu7, lgv7;
  logic signed [LW-1:0] base7, du7, dv7;
  cr_t                  c7;

  always_comb begin
    lgu7 = lg_join(cb[LG_STEPS].pa, 6'd32, lf_u[LG_STEPS]);
    lgv7 = lg_join(cb[LG_STEPS].pb, 6'd32, lf_v[LG_STEPS]);
  end

  always_ff @(posedge clk) begin
    c7    <= cb[LG_STEPS];
    base7 <= BOFS - $signed({8'b0, cb[LG_STEPS].e2}) - cb[LG_STEPS].lgs
             - cb[LG_STEPS].lgx;
    du7   <= lgu7 - cb[LG_STEPS].lgs;
    dv7   <= lgv7 - cb[LG_STEPS].lgs;
  end

  // s8: exponents of f, grad_mu and grad_sigma
  logic signed [LW-1:0] t8 [3];
  cr_t                  c8;

  always_ff @(posedge clk) begin
    c8    <= c7;
    t8[0] <= base7;
    t8[1] <= base7 + du7;
    t8[2] <= base7 + dv7;
  end

  // s9: split each exponent, fraction times ln 2, then the Taylor rows
  tw_t         tw9_next;
  logic [63:0] zp9 [3];
  tw_t         ts_a [0:EXP_TERMS];
  tw_t         ts_m [0:EXP_TERMS-1];
  logic [31:0] z9 [3];
  logic [32:0] et_w [3][0:EXP_TERMS];
  logic [33:0] es_w [3][0:EXP_TERMS];
  logic [31:0] ez_w [3][0:EXP_TERMS];

  always_comb begin
    tw9_next.c = c8;
    for (int i = 0; i < 3; i++) begin
      tw9_next.ln[i].neg = t8[i][LW-1];
      tw9_next.ln[i].cap = ~t8[i][LW-1] && ($unsigned(t8[i]) >= POW2_LIMIT);
      tw9_next.ln[i].n   = t8[i][37:32];
      zp9[i] = 64'(t8[i][31:0]) * 64'(LN2_Q32);
    end
  end

  always_ff @(posedge clk) begin
    ts_a[0] <= tw9_next;
    for (int i = 0; i < 3; i++) z9[i] <= zp9[i][63:32];
    for (int k = 0; k < EXP_TERMS; k++) begin
      ts_m[k]   <= ts_a[k];
      ts_a[k+1] <= ts_m[k];
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    assign et_w[l][0] = TERM_ONE;
    assign es_w[l][0] = '0;
    assign ez_w[l][0] = z9[l];
    for (genvar k = 0; k < EXP_TERMS; k++) begin : g_term
      lrg_exp_cell #(.K(k + 1)) u_exp (
        .clk(clk), .term_in(et_w[l][k]), .sum_in(es_w[l][k]), .z_in(ez_w[l][k]),
        .term(et_w[l][k+1]), .sum(es_w[l][k+1]), .z(ez_w[l][k+1])
      );
    end
  end

  // s10: last term, integer part as a shift, clip
  logic [33:0]      tot10 [3];
  logic [MAG_W-1:0] sh10  [3];
  logic [MAG_W-1:0] mag10 [3];
  cr_t              c10;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tot10[i] = es_w[i][EXP_TERMS] + 34'(et_w[i][EXP_TERMS]);
      if (ts_a[EXP_TERMS].ln[i].n >= 6'd32)
        sh10[i] = MAG_W'(tot10[i]) << (ts_a[EXP_TERMS].ln[i].n - 6'd32);
      else
        sh10[i] = MAG_W'(tot10[i]) >> (6'd32 - ts_a[EXP_TERMS].ln[i].n);
    end
  end

  always_ff @(posedge clk) begin
    c10 <= ts_a[EXP_TERMS].c;
    for (int i = 0; i < 3; i++) begin
      if (ts_a[EXP_TERMS].ln[i].neg) mag10[i] <= '0;
      else if (ts_a[EXP_TERMS].ln[i].cap) mag10[i] <= POW2_CAP;
      else mag10[i] <= sh10[i];
    end
  end

  // s11: signs, residual, saturation
  logic signed [42:0] f11, gmm11, gsm11, rv11, gmv11, gsv11;
  sat_t               cr11, cm11, cs11;
  out_t               result_next;

  always_comb begin
    f11   = c10.tail ? '0 : $signed({2'b00, mag10[0]});
    gmm11 = $signed({2'b00, mag10[1]});
    gsm11 = $signed({2'b00, mag10[2]});
    rv11  = f11 - 43'(c10.y);
    if (c10.tail || c10.uzero) gmv11 = '0;
    else gmv11 = c10.dneg ? gmm11 : -gmm11;
    if (c10.tail || c10.sqone) gsv11 = '0;
    else gsv11 = c10.sqgt ? gsm11 : -gsm11;
    cr11 = clamp32(rv11);
    cm11 = clamp32(gmv11);
    cs11 = clamp32(gsv11);
    if (c10.bad) begin
      result_next              = '0;
      result_next.bad_position = 1'b1;
    end else begin
      result_next.resid        = cr11.v;
      result_next.grad_mu      = cm11.v;
      result_next.grad_sigma   = cs11.v;
      result_next.bad_position = 1'b0;
      result_next.saturated    = cr11.s | cm11.s | cs11.s;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule
`default_nettype wire
